// ===== rtl/core/mt_pkg.sv =====
// Shared constants, command and status types, and word functions for the MT19937 generator.
package mt_pkg;

	localparam int MT_N = 624;
	localparam int MT_M = 397;
	localparam int IDX_W = $clog2(MT_N);

	localparam logic [31:0] MT_MATRIX = 32'h9908_b0df;
	localparam logic [31:0] MT_UPPER = 32'h8000_0000;
	localparam logic [31:0] MT_LOWER = 32'h7fff_ffff;
	localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
	localparam logic [31:0] MT_MASK_B = 32'd2636928640;
	localparam logic [31:0] MT_MASK_C = 32'd4022730752;

	// Request codes of the req_type field.
	localparam logic REQ_SEED = 1'b0;
	localparam logic REQ_EXTRACT = 1'b1;

	// Which address the state memory reads in a cycle.
	typedef enum logic [1:0] {
		RSEL_POS,
		RSEL_NEXT,
		RSEL_FAR
	} mt_rsel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_seed;
		logic seed_mul;
		logic seed_wr;
		logic tw_start;
		logic cap_cur;
		logic cap_next;
		logic tw_wr;
		logic ld_out;
		mt_rsel_t rsel;
	} mt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_last;
		logic pos_zero;
	} mt_status_t;

	// Output tempering with shifts 11, 7, 15 and 18.
	function automatic logic [31:0] mt_temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & MT_MASK_B);
		y = y ^ ((y << 15) & MT_MASK_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// One step of the twist: new word k from words k, k+1 and k+397.
	function automatic logic [31:0] mt_twist(input logic [31:0] cur, input logic [31:0] nxt,
			input logic [31:0] far);
		logic [31:0] y;
		logic [31:0] v;
		y = (cur & MT_UPPER) | (nxt & MT_LOWER);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ MT_MATRIX;
		end
		return v;
	endfunction

endpackage

// ===== rtl/core/mt19937_generator.sv =====
// Top level of the MT19937 32-bit random word generator.
// Usage:
// The input channel (in_valid/in_ready) takes one request word: req_type 0 seeds the
// generator from seed_value and returns nothing; req_type 1 extracts the next tempered
// word, which leaves on the output channel (out_valid/out_ready) as random_word.
// Sequencing:
// An extract reads the word at the read position and tempers it into the output register.
// Every 624th extract, at read position zero, first regenerates the state: each state
// word takes two reads through the single read port and a write. A seed writes word
// zero, then a multiply step and a write step for every further state word because of
// the registered seed multiplier. One request is in progress at a time.
// Reset:
// The read position returns to zero and the state reads as all zeros until the first
// seed; no clearing pass runs, so the block is ready right after reset.
// Stalls:
// A finished word waits in the output register while the next request is accepted; an
// extract that completes while that word is still untaken holds until out_ready.
module mt19937_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_word
);
	import mt_pkg::*;

	mt_cmd_t    cmd;
	mt_status_t status;

	// Sequencer.
	mt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// State memory and arithmetic.
	mt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.seed_value  (seed_value),
		.status      (status),
		.random_word (random_word)
	);

endmodule

// ===== rtl/core/mt_dp.sv =====
// Datapath of the MT19937 generator: state memory, seed multiplier, twist and tempering.
module mt_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  mt_pkg::mt_cmd_t   cmd,
	input  logic [31:0]       seed_value,
	output mt_pkg::mt_status_t status,
	output logic [31:0]       random_word
);
	import mt_pkg::*;

	logic [31:0] mem_q [MT_N];
	logic [31:0] rdata_q;
	logic [31:0] rd_word;
	logic        seeded_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] idx_next;
	logic [IDX_W-1:0] idx_far;
	logic [IDX_W:0]   far_sum;
	logic [IDX_W-1:0] raddr;
	logic [31:0] prev_q;
	logic [31:0] prod_s1;
	logic [31:0] mixed;
	logic [31:0] seed_word;
	logic [31:0] cur_q;
	logic [31:0] next_q;
	logic [31:0] twist_word;
	logic [31:0] out_q;
	logic        we;
	logic [IDX_W-1:0] waddr;
	logic [31:0] wdata;

	// Neighbor indexes of the twist, modulo the state length.
	always_comb begin
		far_sum = {1'b0, idx_q} + (IDX_W+1)'(MT_M);
		if (far_sum >= (IDX_W+1)'(MT_N)) begin
			idx_far = IDX_W'(far_sum - (IDX_W+1)'(MT_N));
		end else begin
			idx_far = far_sum[IDX_W-1:0];
		end
		if (idx_q == IDX_W'(MT_N - 1)) begin
			idx_next = '0;
		end else begin
			idx_next = idx_q + 1'b1;
		end
	end

	// Read address select.
	always_comb begin
		case (cmd.rsel)
			RSEL_NEXT: raddr = idx_next;
			RSEL_FAR:  raddr = idx_far;
			default:   raddr = pos_q;
		endcase
	end

	// Until the first seed the whole state reads as zero, its reset value.
	assign rd_word = seeded_q ? rdata_q : '0;

	// Seed recurrence and twist word.
	assign mixed = prev_q ^ (prev_q >> 30);
	assign seed_word = prod_s1 + 32'(idx_q);
	assign twist_word = mt_twist(cur_q, next_q, rd_word);

	// Write port select.
	always_comb begin
		we = cmd.load_seed | cmd.seed_wr | cmd.tw_wr;
		if (cmd.load_seed) begin
			waddr = '0;
			wdata = seed_value;
		end else if (cmd.seed_wr) begin
			waddr = idx_q;
			wdata = seed_word;
		end else begin
			waddr = idx_q;
			wdata = twist_word;
		end
	end

	// State memory with one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	// Working words and output word.
	always_ff @(posedge clk) begin
		if (cmd.load_seed) begin
			prev_q <= seed_value;
		end else if (cmd.seed_wr) begin
			prev_q <= seed_word;
		end
		if (cmd.seed_mul) begin
			prod_s1 <= 32'(mixed * MT_INIT_MUL);
		end
		if (cmd.cap_cur) begin
			cur_q <= rd_word;
		end else if (cmd.tw_wr) begin
			cur_q <= next_q;
		end
		if (cmd.cap_next) begin
			next_q <= rd_word;
		end
		if (cmd.ld_out) begin
			out_q <= mt_temper(rd_word);
		end
	end

	// Loop index, read position and seeded flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pos_q <= '0;
			seeded_q <= 1'b0;
		end else begin
			if (cmd.load_seed) begin
				idx_q <= IDX_W'(1);
				seeded_q <= 1'b1;
			end else if (cmd.tw_start) begin
				idx_q <= '0;
			end else if (cmd.seed_wr || cmd.tw_wr) begin
				idx_q <= idx_next;
			end
			if (cmd.ld_out) begin
				if (pos_q == IDX_W'(MT_N - 1)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	assign status.idx_last = (idx_q == IDX_W'(MT_N - 1));
	assign status.pos_zero = (pos_q == '0);
	assign random_word = out_q;

	// The read position and the loop index stay inside the state.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < IDX_W'(MT_N))
		else $error("read position out of range");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < IDX_W'(MT_N))
		else $error("loop index out of range");
	// A seed writes word zero directly and starts the recurrence at word one.
	a_seed_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_seed |=> (idx_q == IDX_W'(1)))
		else $error("seed did not start at word one");

endmodule

// ===== rtl/core/mt_ctrl.sv =====
// Controller of the MT19937 generator: handshakes and the seed, twist and extract sequence.
module mt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	output logic               out_valid,
	input  logic               out_ready,
	input  mt_pkg::mt_status_t status,
	output mt_pkg::mt_cmd_t    cmd
);
	import mt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SD_MUL,
		ST_SD_WR,
		ST_TW_FIRST,
		ST_TW_NEXT,
		ST_TW_FAR,
		ST_TW_WR,
		ST_EX_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Command decode and next state.
	always_comb begin
		cmd = '0;
		cmd.rsel = RSEL_POS;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_SEED) begin
						cmd.load_seed = 1'b1;
						state_d = ST_SD_MUL;
					end else if (status.pos_zero) begin
						cmd.tw_start = 1'b1;
						state_d = ST_TW_FIRST;
					end else begin
						state_d = ST_EX_OUT;
					end
				end
			end
			ST_SD_MUL: begin
				cmd.seed_mul = 1'b1;
				state_d = ST_SD_WR;
			end
			ST_SD_WR: begin
				cmd.seed_wr = 1'b1;
				state_d = status.idx_last ? ST_IDLE : ST_SD_MUL;
			end
			ST_TW_FIRST: begin
				cmd.cap_cur = 1'b1;
				cmd.rsel = RSEL_NEXT;
				state_d = ST_TW_FAR;
			end
			ST_TW_NEXT: begin
				cmd.rsel = RSEL_NEXT;
				state_d = ST_TW_FAR;
			end
			ST_TW_FAR: begin
				cmd.cap_next = 1'b1;
				cmd.rsel = RSEL_FAR;
				state_d = ST_TW_WR;
			end
			ST_TW_WR: begin
				cmd.tw_wr = 1'b1;
				state_d = status.idx_last ? ST_EX_OUT : ST_TW_NEXT;
			end
			ST_EX_OUT: begin
				if (out_free) begin
					cmd.ld_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A new word never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");
	// A seed request enters the seed multiply state on the next cycle and produces no word.
	a_seed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_SEED) |=> (state_q == ST_SD_MUL))
		else $error("seed request did not start seeding");
	// An extract at position zero always regenerates the state first.
	a_twist_first: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_EXTRACT && status.pos_zero) |=> (state_q == ST_TW_FIRST))
		else $error("extract at position zero skipped the twist");
	// Nothing is taken in while a request is in progress.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input ready while busy");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the MT19937 random word generator.
`timescale 1ns / 1ps

module testbench;
	import mt_pkg::*;

	// One request word as offered on the input channel.
	typedef struct packed {
		logic        kind;
		logic [31:0] seed;
	} mt_request_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = REQ_SEED;
	logic [31:0] seed_value = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] random_word;

	mt19937_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.seed_value(seed_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.random_word(random_word)
	);

	// Shadow generator state, updated as each request word is accepted.
	logic [31:0] shadow_words [0:MT_N-1];
	int          shadow_pos;

	mt_request_t pending_requests [$];
	logic [31:0] expected_words [$];

	logic in_taken = 1'b0;
	logic calm = 1'b0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	int   words_checked = 0;
	int   fail_count = 0;
	int   cycle_count = 0;
	int   cycle_limit = 0;

	always #2 clk = ~clk;

	// Fill the state from a seed with the standard initialization recurrence.
	task automatic seed_shadow(input logic [31:0] seed);
		logic [31:0] mixed;
		shadow_words[0] = seed;
		for (int i = 1; i < MT_N; i++) begin
			mixed = shadow_words[i-1] ^ (shadow_words[i-1] >> 30);
			shadow_words[i] = mixed * MT_INIT_MUL + 32'(i);
		end
	endtask

	// Regenerate all state words in place; later words see the already updated ones.
	task automatic regenerate_shadow();
		logic [31:0] joined;
		logic [31:0] fresh;
		for (int k = 0; k < MT_N; k++) begin
			joined = {shadow_words[k][31], shadow_words[(k + 1) % MT_N][30:0]};
			fresh = shadow_words[(k + MT_M) % MT_N] ^ {1'b0, joined[31:1]};
			if (joined[0]) begin
				fresh = fresh ^ MT_MATRIX;
			end
			shadow_words[k] = fresh;
		end
	endtask

	function automatic logic [31:0] tempered(input logic [31:0] raw);
		logic [31:0] t;
		t = raw ^ {11'd0, raw[31:11]};
		t = t ^ ({t[24:0], 7'd0} & MT_MASK_B);
		t = t ^ ({t[16:0], 15'd0} & MT_MASK_C);
		t = t ^ {18'd0, t[31:18]};
		return t;
	endfunction

	// Apply one accepted request to the shadow state and queue the word it should return.
	task automatic apply_request(input logic kind, input logic [31:0] seed);
		if (kind == REQ_SEED) begin
			seed_shadow(seed);
		end else begin
			if (shadow_pos == 0) begin
				regenerate_shadow();
			end
			expected_words.push_back(tempered(shadow_words[shadow_pos]));
			shadow_pos = (shadow_pos + 1) % MT_N;
		end
	endtask

	task automatic add_request(input logic kind, input logic [31:0] seed);
		mt_request_t r;
		r.kind = kind;
		r.seed = seed;
		pending_requests.push_back(r);
	endtask

	initial begin
		for (int i = 0; i < MT_N; i++) begin
			shadow_words[i] = 32'd0;
		end
		shadow_pos = 0;
	end

	// Sample both channels at the rising edge; the output is checked before the
	// input is applied so a word never matches a request taken at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected word %08h with nothing pending", random_word);
					end
				end else begin
					if (random_word !== expected_words[0]) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("word %0d: expected %08h, got %08h", words_checked,
								expected_words[0], random_word);
						end
					end
					void'(expected_words.pop_front());
				end
				words_checked++;
			end
			if (in_valid && in_ready) begin
				apply_request(req_type, seed_value);
			end
			in_taken <= in_valid && in_ready;
			calm <= pending_requests.size() < 150;
		end
	end

	// Sender: offers the next request word, sometimes after a short gap.
	always @(negedge clk) begin
		mt_request_t pick;
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_requests.size() != 0) begin
				if (!calm && ((cycle_count / 400) % 3 != 0) && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else begin
					pick = pending_requests.pop_front();
					in_valid <= 1'b1;
					req_type <= pick.kind;
					seed_value <= pick.seed;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: short random stalls, plus one long hold-off so the block backs up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && words_checked >= 300) begin
				hold_done = 1'b1;
				hold_left = 79;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!calm && ((cycle_count / 512) % 3 != 0)
					&& $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_limit != 0 && cycle_count >= cycle_limit) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int n_seed;
		int n_extract;

		// Extracts before any seed run the twist on the all-zero state.
		add_request(REQ_EXTRACT, 32'hffff_ffff);
		add_request(REQ_EXTRACT, 32'd0);
		add_request(REQ_EXTRACT, $urandom());
		// Seed extremes and alternating bit patterns; the read position carries on.
		add_request(REQ_SEED, 32'd0);
		add_request(REQ_EXTRACT, $urandom());
		add_request(REQ_EXTRACT, $urandom());
		add_request(REQ_SEED, 32'hffff_ffff);
		add_request(REQ_EXTRACT, 32'd0);
		add_request(REQ_EXTRACT, 32'hffff_ffff);
		add_request(REQ_SEED, 32'haaaa_aaaa);
		add_request(REQ_EXTRACT, $urandom());
		add_request(REQ_SEED, 32'h5555_5555);
		add_request(REQ_EXTRACT, $urandom());
		add_request(REQ_SEED, 32'd5489);
		add_request(REQ_EXTRACT, $urandom());
		add_request(REQ_EXTRACT, $urandom());
		add_request(REQ_EXTRACT, $urandom());
		// Back-to-back seeds: only the last one counts.
		add_request(REQ_SEED, 32'd1);
		add_request(REQ_SEED, 32'd2);
		add_request(REQ_EXTRACT, $urandom());

		// Random part: mostly extracts so the position wraps a few times, with rare reseeds.
		for (int i = 0; i < 1780; i++) begin
			if ($urandom_range(0, 99) < 3) begin
				add_request(REQ_SEED, $urandom());
			end else begin
				add_request(REQ_EXTRACT, $urandom());
			end
		end

		n_seed = 0;
		n_extract = 0;
		foreach (pending_requests[i]) begin
			if (pending_requests[i].kind == REQ_SEED) begin
				n_seed++;
			end else begin
				n_extract++;
			end
		end
		cycle_limit = 4 * (n_seed * 1300 + n_extract * 15 + (n_extract / MT_N + 2) * 1900 + 100)
			+ 20000;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (pending_requests.size() == 0 && !in_valid);
		wait (expected_words.size() == 0);
		repeat (40) @(posedge clk);

		if (fail_count == 0 && expected_words.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
